// File: rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  // default sizes
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_SUM_WIDTH    = 24;

  // fixed field widths
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int NRM_W = 16;
  // cross product and sign-extended sums (magnitude up to 2^34)
  localparam int VEC_W = 35;
  // magnitude limit before squaring
  localparam int MAG_W = 31;
  // unit length in Q1.14
  localparam int NRM_ONE = 16384;

  // request codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // result of the normalising unit
  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    zero;
  } norm_res_t;

endpackage

// File: rtl/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Sequential vector normaliser: pre-shift, sum of squares, bit-pair integer
// square root, then a restoring divide per component to Q1.14.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [vna_pkg::VEC_W-1:0] vec [3],
  output logic                             done,
  output vna_pkg::norm_res_t               res
);

  localparam int VW = vna_pkg::VEC_W;
  localparam int MW = vna_pkg::MAG_W;
  localparam int NW = vna_pkg::NRM_W;
  localparam int QW = NW - 1;
  localparam logic [QW-1:0] Q_ONE = QW'(vna_pkg::NRM_ONE);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_SQRT  = 7'b0001000,
    N_DSET  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_t;

  nstate_t state;

  logic [VW-1:0]          mag [3];
  logic                   neg [3];
  logic [VW-1:0]          mag_in [3];
  logic                   all_zero;
  logic                   mag_big;
  logic [1:0]             cnt;
  logic [MW-1:0]          sq_op;
  logic [2*MW-1:0]        prod;
  logic [63:0]            sq;
  logic [63:0]            xr;
  logic [63:0]            rt;
  logic [63:0]            bitv;
  logic [63:0]            rt_try;
  logic                   rt_ge;
  logic [63:0]            rt_next;
  logic [31:0]            len;
  logic [1:0]             comp;
  logic [45:0]            num;
  logic [31:0]            rem;
  logic [QW-1:0]          nlo;
  logic [QW-1:0]          quo;
  logic [QW-1:0]          quo_next;
  logic [QW-1:0]          quo_clamp;
  logic [3:0]             dcnt;
  logic [32:0]            rem2;
  logic                   div_ge;
  logic signed [NW-1:0]   nres [3];
  logic signed [NW-1:0]   nval;
  logic                   zero;

  // magnitudes of the incoming vector
  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
      if (vec[i] != '0) all_zero = 1'b0;
    end
  end

  // any magnitude still at or above 2^31
  always_comb begin
    mag_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (mag[i][VW-1:MW] != '0) mag_big = 1'b1;
    end
  end

  // squaring operand
  always_comb begin
    unique case (cnt)
      2'd0:    sq_op = mag[0][MW-1:0];
      2'd1:    sq_op = mag[1][MW-1:0];
      2'd2:    sq_op = mag[2][MW-1:0];
      default: sq_op = '0;
    endcase
  end

  // one square root step per cycle
  always_comb begin
    rt_try  = rt + bitv;
    rt_ge   = (xr >= rt_try);
    rt_next = rt_ge ? ((rt >> 1) + bitv) : (rt >> 1);
  end

  // one quotient bit per cycle
  always_comb begin
    num       = {1'b0, mag[comp][MW-1:0], 14'b0} + {15'b0, len[31:1]};
    rem2      = {rem, nlo[QW-1]};
    div_ge    = (rem2 >= {1'b0, len});
    quo_next  = {quo[QW-2:0], div_ge};
    quo_clamp = (quo_next > Q_ONE) ? Q_ONE : quo_next;
    nval      = neg[comp] ? NW'(-{1'b0, quo_clamp}) : NW'({1'b0, quo_clamp});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i]  <= mag_in[i];
              neg[i]  <= vec[i][VW-1];
              nres[i] <= '0;
            end
            zero  <= all_zero;
            state <= all_zero ? N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mag_big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            cnt   <= '0;
            sq    <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          prod <= sq_op * sq_op;
          sq   <= sq + ((cnt == 2'd0) ? 64'd0 : 64'(prod));
          cnt  <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            xr    <= sq + 64'(prod);
            rt    <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (rt_ge) xr <= xr - rt_try;
          rt   <= rt_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            len   <= (rt_next[31:0] == '0) ? 32'd1 : rt_next[31:0];
            comp  <= '0;
            state <= N_DSET;
          end
        end
        N_DSET: begin
          rem   <= {1'b0, num[45:QW]};
          nlo   <= num[QW-1:0];
          quo   <= '0;
          dcnt  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          rem  <= div_ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
          nlo  <= nlo << 1;
          quo  <= quo_next;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(QW - 1)) begin
            nres[comp] <= nval;
            comp       <= comp + 2'd1;
            state      <= (comp == 2'd2) ? N_DONE : N_DSET;
          end
        end
        N_DONE: begin
          done  <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign res.nx   = nres[0];
  assign res.ny   = nres[1];
  assign res.nz   = nres[2];
  assign res.zero = zero;

endmodule

// File: rtl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Smooth per-vertex normals by summing unit face normals per corner.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one request at a time: write vertex,
// add triangle, read normal or clear all sums. Only a read gives a result on
// the output channel (out_valid/out_ready), held in an output register.
// Work done per request, largely in the shared sequential normaliser:
//   write vertex       a single position memory write
//   add triangle       3 position reads, 6 multiplies, a normalise of
//                      32 root steps and a divide per component, with
//                      pre-shifts for a large cross product, then 3
//                      read-modify-write passes
//   read normal        normalise of the stored sums, result waits in the output register
//   clear all sums     one sum entry zeroed per cycle
// Reset starts the same clearing pass over the sum memory;
// in_ready stays low until it ends. Positions are undefined until written.
// When the receiver stalls, a finished read sits in the output register and
// new requests are still taken; a second read waits before its last step.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
  parameter int SUM_WIDTH    = vna_pkg::DEF_SUM_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [vna_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z,
  input  logic [vna_pkg::IDX_W-1:0]        corner_a,
  input  logic [vna_pkg::IDX_W-1:0]        corner_b,
  input  logic [vna_pkg::IDX_W-1:0]        corner_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z,
  output logic                             zero_sum
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int PW  = vna_pkg::POS_W;
  localparam int DW  = PW + 1;
  localparam int VW  = vna_pkg::VEC_W;
  localparam int NW  = vna_pkg::NRM_W;
  localparam int SW1 = SUM_WIDTH + 1;
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
  localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [11:0] {
    S_CLEAR     = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_RDB       = 12'b000000000100,
    S_RDC       = 12'b000000001000,
    S_LATC      = 12'b000000010000,
    S_CROSS     = 12'b000000100000,
    S_NSTART    = 12'b000001000000,
    S_NORM_WAIT = 12'b000010000000,
    S_ACC_RD    = 12'b000100000000,
    S_ACC_WR    = 12'b001000000000,
    S_RD_CAP    = 12'b010000000000,
    S_OUT       = 12'b100000000000
  } state_t;

  state_t state;

  logic                  in_acc;
  vna_pkg::op_t          op;
  logic                  idx_ok;
  logic                  tri_ok;
  logic [AW-1:0]         clr_cnt;
  logic [AW-1:0]         cnr [3];
  logic [1:0]            kidx;
  logic                  is_read;
  logic [3*PW-1:0]       pa;
  logic [3*PW-1:0]       pb;
  logic [3*PW-1:0]       pc;
  logic signed [DW-1:0]  ab [3];
  logic signed [DW-1:0]  ac [3];
  logic signed [DW-1:0]  mul_a;
  logic signed [DW-1:0]  mul_b;
  logic signed [2*DW-1:0] prod;
  logic signed [VW-1:0]  cr [3];
  logic [2:0]            t;
  logic signed [NW-1:0]  fn [3];
  vna_pkg::norm_res_t    pend;
  vna_pkg::norm_res_t    norm_res;
  logic                  norm_start;
  logic                  norm_done;
  logic signed [VW-1:0]  norm_vec [3];
  logic                  load;

  logic                  pos_we;
  logic [AW-1:0]         pos_waddr;
  logic [3*PW-1:0]       pos_wdata;
  logic [AW-1:0]         pos_raddr;
  logic [3*PW-1:0]       pos_rdata;
  logic                  sum_we;
  logic [AW-1:0]         sum_waddr;
  logic [3*SUM_WIDTH-1:0] sum_wdata;
  logic [AW-1:0]         sum_raddr;
  logic [3*SUM_WIDTH-1:0] sum_rdata;

  logic signed [SUM_WIDTH-1:0] acc  [3];
  logic signed [SW1-1:0]       ssum [3];
  logic [SUM_WIDTH-1:0]        sat  [3];

  // request decode
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign op       = vna_pkg::op_t'(operation);
  assign idx_ok   = ({7'b0, vertex_index} < MAXV);
  assign tri_ok   = ({7'b0, corner_a} < MAXV) && ({7'b0, corner_b} < MAXV)
                    && ({7'b0, corner_c} < MAXV);

  // position memory ports
  assign pos_we    = in_acc && (op == vna_pkg::OP_WRITE) && idx_ok;
  assign pos_waddr = AW'(vertex_index);
  assign pos_wdata = {pos_z, pos_y, pos_x};

  always_comb begin
    unique case (state)
      S_RDB:   pos_raddr = cnr[1];
      S_RDC:   pos_raddr = cnr[2];
      default: pos_raddr = AW'(corner_a);
    endcase
  end

  // edge vectors of the triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = DW'(signed'(pb[PW*i +: PW])) - DW'(signed'(pa[PW*i +: PW]));
      ac[i] = DW'(signed'(pc[PW*i +: PW])) - DW'(signed'(pa[PW*i +: PW]));
    end
  end

  // cross product operand schedule
  always_comb begin
    unique case (t)
      3'd0:    begin mul_a = ab[1]; mul_b = ac[2]; end
      3'd1:    begin mul_a = ab[2]; mul_b = ac[1]; end
      3'd2:    begin mul_a = ab[2]; mul_b = ac[0]; end
      3'd3:    begin mul_a = ab[0]; mul_b = ac[2]; end
      3'd4:    begin mul_a = ab[0]; mul_b = ac[1]; end
      3'd5:    begin mul_a = ab[1]; mul_b = ac[0]; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  // saturating add of the face normal onto a stored sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = signed'(sum_rdata[SUM_WIDTH*i +: SUM_WIDTH]);
      ssum[i] = SW1'(acc[i]) + SW1'(fn[i]);
      if (ssum[i][SUM_WIDTH] != ssum[i][SUM_WIDTH-1]) begin
        sat[i] = ssum[i][SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
        sat[i] = ssum[i][SUM_WIDTH-1:0];
      end
    end
  end

  // sum memory ports
  assign sum_we    = (state == S_CLEAR) || (state == S_ACC_WR);
  assign sum_waddr = (state == S_CLEAR) ? clr_cnt : cnr[kidx];
  assign sum_wdata = (state == S_CLEAR) ? '0 : {sat[2], sat[1], sat[0]};
  assign sum_raddr = (state == S_ACC_RD) ? cnr[kidx] : AW'(vertex_index);

  // normaliser feed: stored sums on a read, cross product otherwise
  assign norm_start = (state == S_RD_CAP) || (state == S_NSTART);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state == S_RD_CAP) ? VW'(acc[i]) : cr[i];
    end
  end

  // output register load
  assign load = (state == S_OUT) && (!out_valid || out_ready);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (op)
              vna_pkg::OP_WRITE: state <= S_IDLE;
              vna_pkg::OP_TRI: begin
                cnr[0] <= AW'(corner_a);
                cnr[1] <= AW'(corner_b);
                cnr[2] <= AW'(corner_c);
                state  <= tri_ok ? S_RDB : S_IDLE;
              end
              vna_pkg::OP_READ: begin
                if (idx_ok) begin
                  state <= S_RD_CAP;
                end else begin
                  pend  <= '{nx: '0, ny: '0, nz: '0, zero: 1'b1};
                  state <= S_OUT;
                end
              end
              vna_pkg::OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDB: begin
          pa    <= pos_rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          pb    <= pos_rdata;
          state <= S_LATC;
        end
        S_LATC: begin
          pc    <= pos_rdata;
          t     <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          prod <= mul_a * mul_b;
          t    <= t + 3'd1;
          unique case (t)
            3'd1: cr[0] <= VW'(prod);
            3'd2: cr[0] <= cr[0] - VW'(prod);
            3'd3: cr[1] <= VW'(prod);
            3'd4: cr[1] <= cr[1] - VW'(prod);
            3'd5: cr[2] <= VW'(prod);
            3'd6: begin
              cr[2] <= cr[2] - VW'(prod);
              state <= S_NSTART;
            end
            default: ;
          endcase
        end
        S_NSTART: begin
          is_read <= 1'b0;
          state   <= S_NORM_WAIT;
        end
        S_RD_CAP: begin
          is_read <= 1'b1;
          state   <= S_NORM_WAIT;
        end
        S_NORM_WAIT: begin
          if (norm_done) begin
            if (is_read) begin
              pend  <= norm_res;
              state <= S_OUT;
            end else if (norm_res.zero) begin
              state <= S_IDLE;
            end else begin
              fn[0] <= norm_res.nx;
              fn[1] <= norm_res.ny;
              fn[2] <= norm_res.nz;
              kidx  <= '0;
              state <= S_ACC_RD;
            end
          end
        end
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: begin
          kidx  <= kidx + 2'd1;
          state <= (kidx == 2'd2) ? S_IDLE : S_ACC_RD;
        end
        S_OUT: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      normal_x <= pend.nx;
      normal_y <= pend.ny;
      normal_z <= pend.nz;
      zero_sum <= pend.zero;
    end
  end

  // position store
  vna_ram #(
    .WIDTH (3 * PW),
    .DEPTH (MAX_VERTICES)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // per-vertex sums
  vna_ram #(
    .WIDTH (3 * SUM_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // shared normaliser
  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vec   (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

  // read-modify-write lands on the entry read the cycle before
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC_WR) |-> (sum_waddr == $past(sum_raddr)))
    else $error("sum write address differs from preceding read");

  // a zero-sum result carries a zero normal
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_sum) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("zero_sum set with non-zero normal");

  // a busy output register holds the next result back
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("result left before output register freed");

  // normaliser finishes only while the sequencer waits for it
  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> (state == S_NORM_WAIT))
    else $error("normaliser done outside wait state");

endmodule
